// ===== rtl/dq_pkg.sv =====
// Package with shared sizes, command codes and the front-to-back operation type.
package dq_pkg;

	// Queue capacity and derived widths.
	localparam int DEPTH = 1024;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = $clog2(2 * DEPTH);

	// Depth of the operation queue between front and back.
	localparam int OPQ_DEPTH = 4;
	localparam int OPQ_IDX_W = $clog2(OPQ_DEPTH);
	localparam int OPQ_CNT_W = $clog2(OPQ_DEPTH + 1);

	localparam int WORD_W = 32;
	localparam logic [WORD_W-1:0] EMPTY_ANSWER = '1;

	// Command codes carried on the kind field.
	typedef enum logic [2:0] {
		KIND_PUSH_FRONT = 3'd0,
		KIND_PUSH_BACK  = 3'd1,
		KIND_POP_FRONT  = 3'd2,
		KIND_POP_BACK   = 3'd3,
		KIND_SIZE       = 3'd4,
		KIND_EMPTY      = 3'd5,
		KIND_FRONT      = 3'd6,
		KIND_BACK       = 3'd7
	} kind_t;

	// One operation for the back end: a store write, or a result that is
	// either read from the store or given directly.
	typedef struct packed {
		logic              we;
		logic              re;
		logic [IDX_W-1:0]  addr;
		logic [WORD_W-1:0] data;
		logic              status;
	} op_t;

endpackage

// ===== rtl/dq_front.sv =====
// Front end: accepts commands, keeps head and count, and issues store operations.
module dq_front import dq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  logic [2:0]        cmd_kind,
	input  logic [WORD_W-1:0] cmd_value,
	input  logic              opq_full,
	output logic              cmd_full,
	output logic              op_valid,
	output op_t               op
);

	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] head_d;
	logic [CNT_W-1:0] count_d;
	logic             accept;
	logic             is_empty;
	logic             is_full;
	logic [SUM_W-1:0] tail_sum;
	logic [SUM_W-1:0] last_sum;
	logic [IDX_W-1:0] tail_pos;
	logic [IDX_W-1:0] last_pos;
	logic [IDX_W-1:0] head_dec;
	logic [IDX_W-1:0] head_inc;
	kind_t            kind;

	assign cmd_full = opq_full;
	assign accept   = cmd_valid && !opq_full;
	assign kind     = kind_t'(cmd_kind);
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CNT_W'(DEPTH));

	// Ring positions: next free slot at the back, last occupied slot, and head moves.
	always_comb begin
		tail_sum = SUM_W'(head_q) + SUM_W'(count_q);
		last_sum = tail_sum - SUM_W'(1);
		tail_pos = (tail_sum >= SUM_W'(DEPTH)) ? IDX_W'(tail_sum - SUM_W'(DEPTH))
		                                       : IDX_W'(tail_sum);
		last_pos = (last_sum >= SUM_W'(DEPTH)) ? IDX_W'(last_sum - SUM_W'(DEPTH))
		                                       : IDX_W'(last_sum);
		head_dec = (head_q == '0) ? IDX_W'(DEPTH - 1) : head_q - IDX_W'(1);
		head_inc = (head_q == IDX_W'(DEPTH - 1)) ? '0 : head_q + IDX_W'(1);
	end

	// Command decode into one operation and the next pointer state.
	always_comb begin
		head_d    = head_q;
		count_d   = count_q;
		op_valid  = 1'b0;
		op.we     = 1'b0;
		op.re     = 1'b0;
		op.addr   = head_q;
		op.data   = EMPTY_ANSWER;
		op.status = 1'b0;
		unique case (kind)
			KIND_PUSH_FRONT: begin
				if (!is_full) begin
					op_valid = 1'b1;
					op.we    = 1'b1;
					op.addr  = head_dec;
					op.data  = cmd_value;
					head_d   = head_dec;
					count_d  = count_q + CNT_W'(1);
				end
			end
			KIND_PUSH_BACK: begin
				if (!is_full) begin
					op_valid = 1'b1;
					op.we    = 1'b1;
					op.addr  = tail_pos;
					op.data  = cmd_value;
					count_d  = count_q + CNT_W'(1);
				end
			end
			KIND_POP_FRONT, KIND_FRONT: begin
				op_valid  = 1'b1;
				op.status = is_empty;
				op.re     = !is_empty;
				op.addr   = head_q;
				if (!is_empty && kind == KIND_POP_FRONT) begin
					head_d  = head_inc;
					count_d = count_q - CNT_W'(1);
				end
			end
			KIND_POP_BACK, KIND_BACK: begin
				op_valid  = 1'b1;
				op.status = is_empty;
				op.re     = !is_empty;
				op.addr   = last_pos;
				if (!is_empty && kind == KIND_POP_BACK) begin
					count_d = count_q - CNT_W'(1);
				end
			end
			KIND_SIZE: begin
				op_valid = 1'b1;
				op.data  = WORD_W'(count_q);
			end
			KIND_EMPTY: begin
				op_valid = 1'b1;
				op.data  = WORD_W'(is_empty);
			end
			default: begin
				op_valid = 1'b0;
			end
		endcase
		op_valid = op_valid && accept;
	end

	// Pointer state advances on each accepted transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count beyond capacity");
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= IDX_W'(DEPTH - 1))
		else $error("head index beyond capacity");
	a_full_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(is_full && op_valid) |-> !op.we)
		else $error("store write issued while queue is full");

endmodule

// ===== rtl/dq_op_fifo.sv =====
// Short operation queue between the front end and the back end.
module dq_op_fifo import dq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  op_t  in_op,
	output logic full,
	output logic out_valid,
	output op_t  out_op,
	input  logic out_take
);

	op_t                  entries_q [OPQ_DEPTH];
	logic [OPQ_IDX_W-1:0] wr_ptr_q;
	logic [OPQ_IDX_W-1:0] rd_ptr_q;
	logic [OPQ_CNT_W-1:0] cnt_q;
	logic                 do_wr;
	logic                 do_rd;

	assign full      = (cnt_q == OPQ_CNT_W'(OPQ_DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_op    = entries_q[rd_ptr_q];
	assign do_wr     = in_valid && !full;
	assign do_rd     = out_take && out_valid;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entries_q[wr_ptr_q] <= in_op;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == OPQ_IDX_W'(OPQ_DEPTH - 1)) ? '0
				                                                    : wr_ptr_q + OPQ_IDX_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == OPQ_IDX_W'(OPQ_DEPTH - 1)) ? '0
				                                                    : rd_ptr_q + OPQ_IDX_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + OPQ_CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - OPQ_CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/dq_back.sv =====
// Back end: carries out store writes and reads and holds the result for transfer.
module dq_back import dq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	input  op_t               op,
	output logic              op_take,
	output logic              empty,
	input  logic              pop,
	output logic [WORD_W-1:0] answer,
	output logic              status
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_s1;
	logic [WORD_W-1:0] imm_s1;
	logic              re_s1;
	logic              status_s1;
	logic              valid_s1;
	logic              out_valid_q;
	logic [WORD_W-1:0] out_answer_q;
	logic              out_status_q;
	logic              out_free;
	logic              s1_free;
	logic              s1_move;
	logic              take_res;

	assign out_free = !out_valid_q || pop;
	assign s1_move  = valid_s1 && out_free;
	assign s1_free  = !valid_s1 || out_free;
	assign op_take  = op_valid && (op.we || s1_free);
	assign take_res = op_take && !op.we;

	assign empty  = !out_valid_q;
	assign answer = out_answer_q;
	assign status = out_status_q;

	// Word store: one write or one registered read per cycle.
	always_ff @(posedge clk) begin
		if (op_take && op.we) begin
			mem[op.addr] <= op.data;
		end
		if (take_res && op.re) begin
			rd_s1 <= mem[op.addr];
		end
	end

	// Result payload of the read stage and the output register.
	always_ff @(posedge clk) begin
		if (take_res) begin
			imm_s1    <= op.data;
			re_s1     <= op.re;
			status_s1 <= op.status;
		end
		if (s1_move) begin
			out_answer_q <= re_s1 ? rd_s1 : imm_s1;
			out_status_q <= status_s1;
		end
	end

	// Valid flags of the read stage and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take_res) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_s1_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |-> !take_res)
		else $error("read stage overwritten while stalled");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pop) |=> (out_valid_q && $stable(out_answer_q)
		                           && $stable(out_status_q)))
		else $error("waiting result changed before transfer");
	a_status_answer: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q) |-> (out_answer_q == EMPTY_ANSWER))
		else $error("empty status without empty answer");

endmodule

// ===== rtl/double_ended_queue_unit.sv =====
// Top level of the double-ended queue unit.
//
// Command channel: kind and value are offered with push; a transfer takes
// place at a rising edge where push is high and full is low. Pushes give no
// result; every other command gives one result (answer, status).
// Result channel: while empty is low the oldest result is on answer and
// status; it transfers at a rising edge where pop is high and empty is low.
// A pop or peek on an empty queue answers -1 with status 1; a push on a full
// queue is dropped silently.
// A result passes through the operation queue, then the read stage, into
// the output register before it shows on the result ports.
// Throughput: one command per cycle while full is low, set by the single
// store port that does one write or one read each cycle.
// The front end keeps head and count and feeds a four-entry operation queue;
// the back end owns the 1024 x 32 store, a read stage and the output register.
// When the receiver stalls, results back up into the operation queue and
// full rises once it holds four operations.
// Reset (arst_n low) empties the queue and all pending results at once; the
// store needs no clearing since only written entries are ever read.
module double_ended_queue_unit import dq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [2:0]        kind,
	input  logic [WORD_W-1:0] value,
	output logic              empty,
	input  logic              pop,
	output logic [WORD_W-1:0] answer,
	output logic              status
);

	logic opq_full;
	logic fe_valid;
	op_t  fe_op;
	logic be_valid;
	op_t  be_op;
	logic be_take;

	dq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (push),
		.cmd_kind  (kind),
		.cmd_value (value),
		.opq_full  (opq_full),
		.cmd_full  (full),
		.op_valid  (fe_valid),
		.op        (fe_op)
	);

	dq_op_fifo u_opq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fe_valid),
		.in_op     (fe_op),
		.full      (opq_full),
		.out_valid (be_valid),
		.out_op    (be_op),
		.out_take  (be_take)
	);

	dq_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (be_valid),
		.op       (be_op),
		.op_take  (be_take),
		.empty    (empty),
		.pop      (pop),
		.answer   (answer),
		.status   (status)
	);

endmodule
